// File: sv/ssdt_pkg.sv
`timescale 1ns / 1ps

package ssdt_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  localparam int unsigned AddrW  = 16;
  localparam int unsigned SeqW   = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned SlotW  = 5;

  typedef enum logic [1:0] {
    OutNew     = 2'd0,
    OutCounted = 2'd1,
    OutDup     = 2'd2,
    OutFull    = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [SeqW-1:0]   last_seq;
    logic [CountW-1:0] recv;
    logic [CountW-1:0] dups;
  } entry_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    outcome_e          outcome;
    logic [CountW-1:0] recv_count;
    logic [CountW-1:0] dup_count;
    logic [CountW-1:0] total_dups;
  } result_t;

  // Slot numbers beyond the 5-bit field keep only their low bits.
  function automatic logic [SlotW-1:0] slot_of(logic [IdxW-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SlotW-1:0];
  endfunction

endpackage

// File: sv/ssdt_in_if.sv
`timescale 1ns / 1ps

interface ssdt_in_if;
  import ssdt_pkg::*;

  logic             valid;
  logic             ready;
  logic [AddrW-1:0] src_addr;
  logic [SeqW-1:0]  seq_count;

  modport source (output valid, output src_addr, output seq_count, input ready);
  modport sink   (input valid, input src_addr, input seq_count, output ready);
endinterface

// File: sv/ssdt_out_if.sv
`timescale 1ns / 1ps

interface ssdt_out_if;
  import ssdt_pkg::*;

  logic              valid;
  logic              ready;
  logic [SlotW-1:0]  slot;
  logic [1:0]        outcome;
  logic [CountW-1:0] recv_count;
  logic [CountW-1:0] dup_count;
  logic [CountW-1:0] total_dups;

  modport source (output valid, output slot, output outcome, output recv_count,
                  output dup_count, output total_dups, input ready);
  modport sink   (input valid, input slot, input outcome, input recv_count,
                  input dup_count, input total_dups, output ready);
endinterface

// File: sv/ssdt_ram.sv
`timescale 1ns / 1ps

module ssdt_ram #(
  parameter int unsigned DataW = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sender_sequence_duplicate_table.sv
`timescale 1ns / 1ps

// Per-sender duplicate detector. Each input beat carries a sender address and
// its sequence count; the table is searched from slot zero upward through a
// single-port-read RAM, one entry read per cycle with the compare in the cycle
// after its read. The fill count (slots in use) is at most 32. Slots are taken
// in order and never released, so a fill count stands in for per-entry valid
// bits and no clearing pass is needed after reset. The result sits in an
// output register, and the next input beat is taken once that result has been
// handed over to it, even while it still waits to be taken downstream.
module sender_sequence_duplicate_table (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssdt_in_if.sink    in_i,
  ssdt_out_if.source out_o
);
  import ssdt_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSearch = 3'b010,
    StResult = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [AddrW-1:0]  key_addr_q, key_addr_d;
  logic [SeqW-1:0]   key_seq_q, key_seq_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  logic [CountW-1:0] total_q, total_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_vld_q, out_vld_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  entry_t          ram_rdata;
  logic            hit;

  ssdt_ram #(
    .DataW($bits(entry_t)),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == StIdle);

  assign out_o.valid      = out_vld_q;
  assign out_o.slot       = out_q.slot;
  assign out_o.outcome    = out_q.outcome;
  assign out_o.recv_count = out_q.recv_count;
  assign out_o.dup_count  = out_q.dup_count;
  assign out_o.total_dups = out_q.total_dups;

  // Read data belongs to chk_idx_q only in the cycle after its read was issued.
  assign hit = chk_vld_q && (ram_rdata.addr == key_addr_q);

  always_comb begin
    state_d    = state_q;
    key_addr_d = key_addr_q;
    key_seq_d  = key_seq_q;
    fill_d     = fill_q;
    issue_d    = issue_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    total_d    = total_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    ram_we     = 1'b0;
    ram_waddr  = chk_idx_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = issue_q[IdxW-1:0];

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          key_addr_d = in_i.src_addr;
          key_seq_d  = in_i.seq_count;
          issue_d    = '0;
          state_d    = StSearch;
        end
      end

      StSearch: begin
        if (hit) begin
          ram_we         = 1'b1;
          ram_waddr      = chk_idx_q;
          ram_wdata      = ram_rdata;
          res_d.slot     = slot_of(chk_idx_q);
          if (ram_rdata.last_seq != key_seq_q) begin
            ram_wdata.recv     = ram_rdata.recv + CountW'(1);
            ram_wdata.last_seq = key_seq_q;
            res_d.outcome      = OutCounted;
          end else begin
            ram_wdata.dups = ram_rdata.dups + CountW'(1);
            total_d        = total_q + CountW'(1);
            res_d.outcome  = OutDup;
          end
          res_d.recv_count = ram_wdata.recv;
          res_d.dup_count  = ram_wdata.dups;
          res_d.total_dups = total_d;
          state_d          = StResult;
        end else if (issue_q == fill_q) begin
          // Every used slot has been compared without a match.
          if (fill_q != CntW'(TableDepth)) begin
            ram_we             = 1'b1;
            ram_waddr          = fill_q[IdxW-1:0];
            ram_wdata.addr     = key_addr_q;
            ram_wdata.last_seq = key_seq_q;
            ram_wdata.recv     = CountW'(1);
            ram_wdata.dups     = '0;
            fill_d             = fill_q + CntW'(1);
            res_d.slot         = slot_of(fill_q[IdxW-1:0]);
            res_d.outcome      = OutNew;
            res_d.recv_count   = CountW'(1);
            res_d.dup_count    = '0;
          end else begin
            res_d.slot       = '0;
            res_d.outcome    = OutFull;
            res_d.recv_count = '0;
            res_d.dup_count  = '0;
          end
          res_d.total_dups = total_q;
          state_d          = StResult;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = issue_q[IdxW-1:0];
          chk_vld_d = 1'b1;
          chk_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + CntW'(1);
        end
      end

      StResult: begin
        if (!out_vld_q || out_o.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      issue_q   <= '0;
      chk_vld_q <= 1'b0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      issue_q   <= issue_d;
      chk_vld_q <= chk_vld_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_addr_q <= key_addr_d;
    key_seq_q  <= key_seq_d;
    chk_idx_q  <= chk_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule
